// ===== rtl/core/snfcs_pkg.sv =====
`default_nettype none
package snfcs_pkg;

  localparam int PageBytes  = 256;
  localparam int ReadMax    = 256;
  localparam int ScriptLen  = 8;
  localparam int StepIdxW   = $clog2(ScriptLen);
  localparam int LenW       = $clog2(ScriptLen + 1);

  localparam logic [7:0] OpFastRead = 8'h0B;
  localparam logic [7:0] OpWren     = 8'h06;
  localparam logic [7:0] OpVwren    = 8'h50;
  localparam logic [7:0] OpWrdi     = 8'h04;
  localparam logic [7:0] OpErase64  = 8'hD8;
  localparam logic [7:0] OpRdsr1    = 8'h05;
  localparam logic [7:0] DummyByte  = 8'h00;

  typedef enum logic [2:0] {
    ACT_STAT_READ  = 3'd0,
    ACT_STAT_WRITE = 3'd1,
    ACT_READ       = 3'd2,
    ACT_PROG_START = 3'd3,
    ACT_PROG_DATA  = 3'd4,
    ACT_ERASE      = 3'd5,
    ACT_WRITE_DIS  = 3'd6,
    ACT_RESPONSE   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_RECV   = 3'd1,
    KIND_END    = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_STATUS = 3'd4,
    KIND_DONE   = 3'd5,
    KIND_REJECT = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STAT,
    PH_READ,
    PH_PPOLL1,
    PH_PDATA,
    PH_PPOLL2,
    PH_EPOLL1,
    PH_EPOLL2,
    PH_EPOLL3
  } phase_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  command_byte;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [8:0]  byte_count;
    logic        last;
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [8:0] count;
    logic       last_of_run;
  } rsp_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } step_t;

  // All results caused by one input transaction; count belongs to the receive step.
  typedef struct packed {
    step_t [ScriptLen-1:0] steps;
    logic [LenW-1:0]       len;
    logic [8:0]            count;
  } script_t;

  function automatic script_t add_step(script_t s, kind_t k, logic [7:0] v);
    script_t r;
    r = s;
    r.steps[s.len[StepIdxW-1:0]].kind  = k;
    r.steps[s.len[StepIdxW-1:0]].value = v;
    r.len = s.len + LenW'(1);
    return r;
  endfunction

  function automatic logic [7:0] read_status_op(logic [1:0] reg_num);
    logic [7:0] op;
    case (reg_num)
      2'd1:    op = 8'h05;
      2'd2:    op = 8'h35;
      default: op = 8'h15;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] write_status_op(logic [1:0] reg_num);
    logic [7:0] op;
    case (reg_num)
      2'd1:    op = 8'h01;
      2'd2:    op = 8'h31;
      default: op = 8'h11;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spi_nor_flash_command_sequencer_top.sv =====
`default_nettype none
// SPI NOR flash command sequencer, byte level.
// The req channel takes host commands and the bytes that the flash returns
// (action 7). The rsp channel gives framed byte sends, receive requests,
// frame ends, read data, status values, done and rejects; last_of_run marks
// the final result caused by one req transaction.
// A req transaction is decoded in the cycle it is accepted: the sequencing
// state advances and all its results, one to eight, go into a two-entry
// queue. The back end drains the queue into an output register, one result
// per cycle while rsp_ready allows; each result is held in a queue entry
// and then in the output register. req_ready is high whenever the queue
// has room, so commands can arrive in consecutive cycles; the sustained
// rate is set by the output register at one result per cycle while
// rsp_ready is high. A stray flash response makes no result.
// While rsp_ready is low the current result holds, the queue fills, and
// req_ready drops once both queue entries are taken.
// Synchronous reset returns the sequencer to idle and empties the queue
// and the output register.
module spi_nor_flash_command_sequencer_top
  import snfcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  logic    accept;
  logic    push;
  logic    pop;
  logic    full;
  logic    head_valid;
  script_t script;
  script_t head;

  assign req_ready = !full;
  assign accept    = req_valid && req_ready;

  snfcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .push   (push),
    .script (script)
  );

  snfcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (script),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  snfcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/core/snfcs_front.sv =====
`default_nettype none
module snfcs_front
  import snfcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire req_t    req,
  output logic         push,
  output script_t      script
);

  phase_t      phase, phase_next;
  logic [7:0]  pending_opcode, pending_opcode_next;
  logic [23:0] pending_address, pending_address_next;
  logic [8:0]  receive_remaining, receive_remaining_next;

  logic        reg_ok;
  logic        poll_phase;
  logic        busy_bit;
  logic [8:0]  read_len;
  logic [8:0]  data_total;
  logic [8:0]  read_left;

  always_comb begin
    reg_ok     = req.command_byte inside {[8'd1:8'd3]};
    poll_phase = phase inside {PH_PPOLL1, PH_PPOLL2, PH_EPOLL1, PH_EPOLL2, PH_EPOLL3};
    busy_bit   = req.data_byte[0];
    read_len   = (req.byte_count > 9'(ReadMax)) ? 9'(ReadMax) : req.byte_count;
    data_total = receive_remaining + 9'd1;
    read_left  = (receive_remaining != 9'd0) ? receive_remaining - 9'd1 : 9'd0;
  end

  // Next state and operation context.
  always_comb begin
    phase_next             = phase;
    pending_opcode_next    = pending_opcode;
    pending_address_next   = pending_address;
    receive_remaining_next = receive_remaining;
    if (accept) begin
      case (req.action)
        ACT_RESPONSE: begin
          if (phase == PH_STAT) begin
            phase_next = PH_IDLE;
          end else if (phase == PH_READ) begin
            receive_remaining_next = read_left;
            if (read_left == 9'd0) phase_next = PH_IDLE;
          end else if (poll_phase && !busy_bit) begin
            case (phase)
              PH_PPOLL1: begin
                phase_next             = PH_PDATA;
                receive_remaining_next = 9'd0;
              end
              PH_EPOLL1: phase_next = PH_EPOLL2;
              PH_EPOLL2: phase_next = PH_EPOLL3;
              default:   phase_next = PH_IDLE;
            endcase
          end
        end
        ACT_PROG_DATA: begin
          if (phase == PH_PDATA) begin
            receive_remaining_next = data_total;
            if (req.last || data_total >= 9'(PageBytes)) phase_next = PH_PPOLL2;
          end
        end
        default: begin
          if (phase == PH_IDLE) begin
            case (req.action)
              ACT_STAT_READ: begin
                if (reg_ok) phase_next = PH_STAT;
              end
              ACT_READ: begin
                if (read_len != 9'd0) begin
                  receive_remaining_next = read_len;
                  phase_next             = PH_READ;
                end
              end
              ACT_PROG_START: begin
                pending_opcode_next  = req.command_byte;
                pending_address_next = req.address;
                phase_next           = PH_PPOLL1;
              end
              ACT_ERASE: begin
                pending_address_next = req.address;
                phase_next           = PH_EPOLL1;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Results of the transaction, built step by step.
  always_comb begin
    script = '0;
    if (accept) begin
      case (req.action)
        ACT_RESPONSE: begin
          if (phase == PH_STAT) begin
            script = add_step(script, KIND_END, 8'd0);
            script = add_step(script, KIND_STATUS, req.data_byte);
            script = add_step(script, KIND_DONE, 8'd0);
          end else if (phase == PH_READ) begin
            script = add_step(script, KIND_DATA, req.data_byte);
            if (read_left == 9'd0) begin
              script = add_step(script, KIND_END, 8'd0);
              script = add_step(script, KIND_DONE, 8'd0);
            end
          end else if (poll_phase) begin
            if (busy_bit) begin
              script       = add_step(script, KIND_RECV, 8'd0);
              script.count = 9'd1;
            end else begin
              script = add_step(script, KIND_END, 8'd0);
              case (phase)
                PH_PPOLL1: begin
                  script = add_step(script, KIND_SEND, OpWren);
                  script = add_step(script, KIND_END, 8'd0);
                  script = add_step(script, KIND_SEND, pending_opcode);
                  script = add_step(script, KIND_SEND, pending_address[23:16]);
                  script = add_step(script, KIND_SEND, pending_address[15:8]);
                  script = add_step(script, KIND_SEND, pending_address[7:0]);
                end
                PH_EPOLL1: begin
                  script       = add_step(script, KIND_SEND, OpWren);
                  script       = add_step(script, KIND_END, 8'd0);
                  script       = add_step(script, KIND_SEND, OpRdsr1);
                  script       = add_step(script, KIND_RECV, 8'd0);
                  script.count = 9'd1;
                end
                PH_EPOLL2: begin
                  script       = add_step(script, KIND_SEND, OpErase64);
                  script       = add_step(script, KIND_SEND, pending_address[23:16]);
                  script       = add_step(script, KIND_SEND, pending_address[15:8]);
                  script       = add_step(script, KIND_SEND, pending_address[7:0]);
                  script       = add_step(script, KIND_END, 8'd0);
                  script       = add_step(script, KIND_SEND, OpRdsr1);
                  script       = add_step(script, KIND_RECV, 8'd0);
                  script.count = 9'd1;
                end
                default: begin
                  script = add_step(script, KIND_DONE, 8'd0);
                end
              endcase
            end
          end
        end
        ACT_PROG_DATA: begin
          if (phase != PH_PDATA) begin
            script = add_step(script, KIND_REJECT, 8'd0);
          end else begin
            script = add_step(script, KIND_SEND, req.data_byte);
            if (req.last || data_total >= 9'(PageBytes)) begin
              script       = add_step(script, KIND_END, 8'd0);
              script       = add_step(script, KIND_SEND, OpRdsr1);
              script       = add_step(script, KIND_RECV, 8'd0);
              script.count = 9'd1;
            end
          end
        end
        default: begin
          if (phase != PH_IDLE) begin
            script = add_step(script, KIND_REJECT, 8'd0);
          end else begin
            case (req.action)
              ACT_STAT_READ: begin
                if (!reg_ok) begin
                  script = add_step(script, KIND_REJECT, 8'd0);
                end else begin
                  script = add_step(script, KIND_SEND,
                                    read_status_op(req.command_byte[1:0]));
                  script       = add_step(script, KIND_RECV, 8'd0);
                  script.count = 9'd1;
                end
              end
              ACT_STAT_WRITE: begin
                if (!reg_ok) begin
                  script = add_step(script, KIND_REJECT, 8'd0);
                end else begin
                  script = add_step(script, KIND_SEND, OpVwren);
                  script = add_step(script, KIND_END, 8'd0);
                  script = add_step(script, KIND_SEND,
                                    write_status_op(req.command_byte[1:0]));
                  script = add_step(script, KIND_SEND, req.data_byte);
                  script = add_step(script, KIND_END, 8'd0);
                  script = add_step(script, KIND_DONE, 8'd0);
                end
              end
              ACT_READ: begin
                script = add_step(script, KIND_SEND, req.command_byte);
                script = add_step(script, KIND_SEND, req.address[23:16]);
                script = add_step(script, KIND_SEND, req.address[15:8]);
                script = add_step(script, KIND_SEND, req.address[7:0]);
                if (req.command_byte == OpFastRead) begin
                  script = add_step(script, KIND_SEND, DummyByte);
                end
                if (read_len == 9'd0) begin
                  script = add_step(script, KIND_END, 8'd0);
                  script = add_step(script, KIND_DONE, 8'd0);
                end else begin
                  script       = add_step(script, KIND_RECV, 8'd0);
                  script.count = read_len;
                end
              end
              ACT_PROG_START, ACT_ERASE: begin
                script       = add_step(script, KIND_SEND, OpRdsr1);
                script       = add_step(script, KIND_RECV, 8'd0);
                script.count = 9'd1;
              end
              default: begin
                script = add_step(script, KIND_SEND, OpWrdi);
                script = add_step(script, KIND_END, 8'd0);
                script = add_step(script, KIND_DONE, 8'd0);
              end
            endcase
          end
        end
      endcase
    end
  end

  // A flash response that nothing waits for leaves an empty script behind.
  assign push = accept && (script.len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      pending_opcode    <= 8'd0;
      pending_address   <= 24'd0;
      receive_remaining <= 9'd0;
    end else begin
      phase             <= phase_next;
      pending_opcode    <= pending_opcode_next;
      pending_address   <= pending_address_next;
      receive_remaining <= receive_remaining_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/snfcs_queue.sv =====
`default_nettype none
module snfcs_queue
  import snfcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire script_t push_data,
  input  wire logic    pop,
  output logic         full,
  output logic         head_valid,
  output script_t      head
);

  script_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/snfcs_back.sv =====
`default_nettype none
module snfcs_back
  import snfcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire script_t head,
  output logic         pop,
  output logic         rsp_valid,
  input  wire logic    rsp_ready,
  output rsp_t         rsp
);

  logic [StepIdxW-1:0] idx;
  logic                load;
  logic                at_last;
  step_t               cur;

  assign cur     = head.steps[idx];
  assign at_last = (LenW'(idx) == head.len - LenW'(1));
  assign load    = head_valid && (!rsp_valid || rsp_ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.kind        <= cur.kind;
      rsp.value       <= cur.value;
      rsp.count       <= (cur.kind == KIND_RECV) ? head.count : 9'd0;
      rsp.last_of_run <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (load) idx <= at_last ? '0 : idx + StepIdxW'(1);
    end
  end

  a_idx_in_script: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (LenW'(idx) < head.len))
    else $error("step index runs past the end of the script");

  a_idx_reset_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("step index not rewound after the script was retired");

  a_count_only_on_recv: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind != KIND_RECV) |-> (rsp.count == 9'd0))
    else $error("nonzero count on a result that is not a receive request");

  a_recv_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_RECV) |-> (rsp.count != 9'd0))
    else $error("receive request with zero count");

endmodule
`default_nettype wire
